@@ hw/rtl/ntt_tw_pkg.sv @@
// Shared types and codes for the NTT twiddle generator.
package ntt_tw_pkg;

  typedef enum logic [1:0] {
    CMD_FWD  = 2'd0,
    CMD_INV  = 2'd1,
    CMD_NINV = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_ROOT    = 2'd1,
    REG_LOGLEN  = 2'd2,
    REG_NONE    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_START_RED,
    OP_STEP_RED,
    OP_INIT_FIRST,
    OP_INIT_SECOND,
    OP_START_MUL_R,
    OP_START_MUL_B,
    OP_STEP_MUL,
    OP_WR_R,
    OP_WR_B,
    OP_START_SH,
    OP_STEP_SH,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
    logic last;
    logic skip;
    logic need_second;
    logic out_busy;
  } status_t;

endpackage

@@ hw/rtl/ntt_tw_datapath.sv @@
// Datapath: config registers, bit-serial modular unit, exponent and output registers.
module ntt_tw_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ntt_tw_pkg::op_e         op_i,
  output ntt_tw_pkg::status_t     status_o,
  input  logic                    cfg_valid_i,
  input  logic [1:0]              cfg_addr_i,
  input  logic [63:0]             cfg_data_i,
  input  logic [1:0]              cmd_i,
  input  logic [16:0]             index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [63:0]             value_o,
  output logic [63:0]             shoup_factor_o,
  output logic                    out_of_range_o
);
  import ntt_tw_pkg::*;

  logic [63:0] mod_q, root_q;
  logic [4:0]  lg_q;
  logic [1:0]  cmd_q;
  logic [16:0] idx_q;
  logic [63:0] acc_q, acc_d, x_q, x_d, a_q, a_d, r_q, r_d, b_q, b_d, e_q, e_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        ov_q;
  logic [63:0] val_q, sh_q;
  logic        oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= 64'd3;
      root_q <= 64'd1;
      lg_q   <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MODULUS: mod_q  <= cfg_data_i;
        REG_ROOT:    root_q <= cfg_data_i;
        REG_LOGLEN:  lg_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Derived values for the latched request
  logic        oor, qvalid;
  logic [63:0] n_val, brv;
  logic [31:0] rev32;
  always_comb begin
    oor    = ((cmd_q == CMD_FWD) || (cmd_q == CMD_INV)) &&
             (lg_q < 5'd17) && ((idx_q >> lg_q) != 17'd0);
    qvalid = mod_q >= 64'd2;
    n_val  = 64'd1 << lg_q;
    rev32  = '0;
    for (int k = 0; k < 17; k++) rev32[31 - k] = idx_q[k];
    // rev32 holds idx reversed over 32 bits; align to lg bits
    brv = {32'd0, rev32} >> (6'd32 - {1'b0, lg_q});
  end

  // Step arithmetic
  logic [64:0] red_t, dbl_t, add_t, sh_t;
  logic [63:0] dbl_m, mul_m, red_m, sh_m;
  logic        sh_take;
  always_comb begin
    red_t = {acc_q, x_q[63]};
    red_m = (red_t >= {1'b0, mod_q}) ? 64'(red_t - {1'b0, mod_q}) : red_t[63:0];
    dbl_t = {acc_q, 1'b0};
    dbl_m = (dbl_t >= {1'b0, mod_q}) ? 64'(dbl_t - {1'b0, mod_q}) : dbl_t[63:0];
    add_t = {1'b0, dbl_m} + {1'b0, a_q};
    mul_m = !x_q[63] ? dbl_m :
            (add_t >= {1'b0, mod_q}) ? 64'(add_t - {1'b0, mod_q}) : add_t[63:0];
    sh_t    = {acc_q, 1'b0};
    sh_take = acc_q[63] || (sh_t[63:0] >= mod_q);
    sh_m    = sh_take ? (sh_t[63:0] - mod_q) : sh_t[63:0];
  end

  always_comb begin
    acc_d = acc_q; x_d = x_q; a_d = a_q; r_d = r_q; b_d = b_q; e_d = e_q;
    cnt_d = cnt_q + 6'd1;
    case (op_i)
      OP_START_RED: begin
        acc_d = '0; cnt_d = '0;
        x_d   = (cmd_q == CMD_NINV) ? n_val : root_q;
      end
      OP_STEP_RED: begin acc_d = red_m; x_d = {x_q[62:0], 1'b0}; end
      OP_INIT_FIRST: begin
        b_d = acc_q; r_d = 64'd1;
        e_d = (cmd_q == CMD_FWD) ? brv : (mod_q - 64'd2);
      end
      OP_INIT_SECOND: begin b_d = r_q; r_d = 64'd1; e_d = brv; end
      OP_START_MUL_R: begin a_d = r_q; x_d = b_q; acc_d = '0; cnt_d = '0; end
      OP_START_MUL_B: begin a_d = b_q; x_d = b_q; acc_d = '0; cnt_d = '0; end
      OP_STEP_MUL: begin acc_d = mul_m; x_d = {x_q[62:0], 1'b0}; end
      OP_WR_R: begin
        r_d = acc_q; a_d = b_q; x_d = b_q; acc_d = '0; cnt_d = '0;
      end
      OP_WR_B: begin b_d = acc_q; e_d = {1'b0, e_q[63:1]}; end
      OP_START_SH: begin acc_d = r_q; x_d = '0; cnt_d = '0; end
      OP_STEP_SH: begin acc_d = sh_m; x_d = {x_q[62:0], sh_take}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; x_q <= x_d; a_q <= a_d; r_q <= r_d; b_q <= b_d; e_q <= e_d;
    cnt_q <= cnt_d;
    if (op_i == OP_LATCH) begin
      cmd_q <= cmd_i;
      idx_q <= index_i;
    end
  end

  logic skip;
  assign skip = (cmd_q == CMD_NONE) || !qvalid || oor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (op_i == OP_LOAD_OUT) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD_OUT) begin
      val_q <= skip ? '0 : r_q;
      sh_q  <= skip ? '0 : x_q;
      oor_q <= oor;
    end
  end

  assign status_o = '{e_zero: (e_q == '0), e_lsb: e_q[0], last: (cnt_q == 6'd63),
                      skip: skip, need_second: (cmd_q == CMD_INV),
                      out_busy: ov_q && !out_ready_i};
  assign out_valid_o    = ov_q;
  assign value_o        = val_q;
  assign shoup_factor_o = sh_q;
  assign out_of_range_o = oor_q;

endmodule

@@ hw/rtl/ntt_tw_ctrl.sv @@
// Controller: sequences reduction, square-and-multiply and Shoup division.
module ntt_tw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ntt_tw_pkg::status_t status_i,
  output ntt_tw_pkg::op_e     op_o
);
  import ntt_tw_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHECK = 11'b000_0000_0010,
    ST_RED   = 11'b000_0000_0100,
    ST_INIT  = 11'b000_0000_1000,
    ST_POW   = 11'b000_0001_0000,
    ST_MUL_R = 11'b000_0010_0000,
    ST_WR_R  = 11'b000_0100_0000,
    ST_MUL_B = 11'b000_1000_0000,
    ST_WR_B  = 11'b001_0000_0000,
    ST_SHOUP = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    op_o     = OP_NOP;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        op_o = OP_LATCH; second_d = 1'b0; state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.skip) begin
          state_d = ST_DONE;
        end else begin
          op_o = OP_START_RED; state_d = ST_RED;
        end
      end
      ST_RED: begin
        op_o = OP_STEP_RED;
        if (status_i.last) state_d = ST_INIT;
      end
      ST_INIT: begin
        op_o = OP_INIT_FIRST; state_d = ST_POW;
      end
      ST_POW: begin
        if (status_i.e_zero) begin
          if (status_i.need_second && !second_q) begin
            op_o = OP_INIT_SECOND; second_d = 1'b1;
          end else begin
            op_o = OP_START_SH; state_d = ST_SHOUP;
          end
        end else if (status_i.e_lsb) begin
          op_o = OP_START_MUL_R; state_d = ST_MUL_R;
        end else begin
          op_o = OP_START_MUL_B; state_d = ST_MUL_B;
        end
      end
      ST_MUL_R: begin
        op_o = OP_STEP_MUL;
        if (status_i.last) state_d = ST_WR_R;
      end
      // product into r, then square b
      ST_WR_R: begin
        op_o = OP_WR_R; state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        op_o = OP_STEP_MUL;
        if (status_i.last) state_d = ST_WR_B;
      end
      ST_WR_B: begin
        op_o = OP_WR_B; state_d = ST_POW;
      end
      ST_SHOUP: begin
        op_o = OP_STEP_SH;
        if (status_i.last) state_d = ST_DONE;
      end
      ST_DONE: if (!status_i.out_busy) begin
        op_o = OP_LOAD_OUT; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

@@ hw/rtl/ntt_twiddle_generator.sv @@
// Top level of the NTT twiddle generator.
// Answers one request at a time: forward twiddle root^brv(index), inverse twiddle
// (root^(q-2))^brv(index), or n^(q-2), each with floor(value*2^64/q). All work runs
// on one bit-serial modular unit: a reduction, then square-and-multiply over each
// exponent used (q-2 and/or the reversed index, up to its top set bit), squaring for
// every bit and multiplying in for every set bit, then the Shoup quotient; an inverse
// twiddle works through its two exponents in turn. Out-of-range, unused-command and
// modulus-below-two requests skip all of this and give a zero result. A stalled
// output holds the next result back until the output register is free.
// A new request is taken while the previous result still waits at the output register.
module ntt_twiddle_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [16:0] index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [63:0] shoup_factor_o,
  output logic        out_of_range_o
);
  import ntt_tw_pkg::*;

  op_e     op;
  status_t status;

  ntt_tw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .status_i (status),
    .op_o     (op)
  );

  ntt_tw_datapath u_dp (
    .clk_i, .rst_ni,
    .op_i (op),
    .status_o (status),
    .cfg_valid_i, .cfg_addr_i, .cfg_data_i,
    .cmd_i, .index_i,
    .out_valid_o, .out_ready_i, .value_o, .shoup_factor_o, .out_of_range_o
  );

  assign cfg_ready_o = 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (value_o == '0 && shoup_factor_o == '0))
    else $error("out-of-range result not zero");

endmodule

@@ sim/ntt_twiddle_generator_test.sv @@
// Self-checking testbench for the NTT twiddle generator: directed and random requests.
module ntt_twiddle_generator_test;
  import ntt_tw_pkg::*;

  localparam int unsigned IdleLimit = 200000;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] shoup;
    logic        oor;
  } twiddle_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [16:0] index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] value_o;
  logic [63:0] shoup_factor_o;
  logic        out_of_range_o;

  ntt_twiddle_generator dut (.*);

  always #4 clk_i = ~clk_i;

  // shadow of the configuration registers
  logic [63:0] cur_mod = 64'd3;
  logic [63:0] cur_root = 64'd1;
  logic [4:0]  cur_log = 5'd1;

  twiddle_t pending_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_cfg = 0;
  int unsigned idle_cycles = 0;
  int unsigned out_stall = 0;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, q});
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] q);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1 % q;
    b = base % q;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, q);
      b = mul_mod(b, b, q);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] shoup_quot(logic [63:0] v, logic [63:0] q);
    logic [127:0] num;
    num = {v, 64'd0};
    return 64'(num / {64'd0, q});
  endfunction

  function automatic twiddle_t predict_twiddle(cmd_e c, logic [16:0] ix);
    twiddle_t t;
    logic [63:0] q;
    logic [63:0] n;
    logic [63:0] base;
    logic [63:0] rev;
    logic [63:0] v;
    q = cur_mod;
    n = 64'd1 << cur_log;
    t = '0;
    if (c == CMD_FWD || c == CMD_INV) begin
      if ({47'd0, ix} >= n) begin
        t.oor = 1'b1;
      end else if (q >= 2) begin
        base = cur_root % q;
        if (c == CMD_INV) base = pow_mod(base, q - 2, q);
        rev = '0;
        v = {47'd0, ix};
        for (int k = 0; k < cur_log; k++) begin
          rev = (rev << 1) | {63'd0, v[0]};
          v = v >> 1;
        end
        t.value = pow_mod(base, rev, q);
        t.shoup = shoup_quot(t.value, q);
      end
    end else if (c == CMD_NINV && q >= 2) begin
      t.value = pow_mod(n % q, q - 2, q);
      t.shoup = shoup_quot(t.value, q);
    end
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %h want %h", n_checked, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    twiddle_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected value", value_o, '0);
      end else begin
        w = pending_q.pop_front();
        if (value_o !== w.value) report_mismatch("value", value_o, w.value);
        if (shoup_factor_o !== w.shoup) report_mismatch("shoup", shoup_factor_o, w.shoup);
        if (out_of_range_o !== w.oor) report_mismatch("oor", 64'(out_of_range_o), 64'(w.oor));
      end
      n_checked++;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 7) == 0) out_stall <= gap_len();
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results pending", pending_q.size());
      $display("ntt_twiddle_generator_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(cmd_e c, logic [16:0] ix);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    index_i <= ix;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q = {pending_q, predict_twiddle(c, ix)};
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [63:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_MODULUS: cur_mod = d;
      REG_ROOT:    cur_root = d;
      REG_LOGLEN:  cur_log = d[4:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic setup(logic [63:0] q, logic [63:0] r, logic [4:0] lg);
    drain();
    write_reg(REG_MODULUS, q);
    write_reg(REG_ROOT, r);
    write_reg(REG_LOGLEN, {59'd0, lg});
  endtask

  task automatic test_reset_state();
    send_req(CMD_FWD, 17'd0);
    send_req(CMD_FWD, 17'd1);
    send_req(CMD_INV, 17'd1);
    send_req(CMD_FWD, 17'd2);
    send_req(CMD_NINV, 17'h1ffff);
    send_req(CMD_NONE, 17'd0);
  endtask

  task automatic test_directed();
    setup(64'd17, 64'd3, 5'd3);
    send_req(CMD_FWD, 17'd0);
    send_req(CMD_FWD, 17'd7);
    send_req(CMD_INV, 17'd5);
    send_req(CMD_FWD, 17'd8);
    send_req(CMD_INV, 17'h1ffff);
    send_req(CMD_NINV, 17'd3);
    send_req(CMD_NONE, 17'h1ffff);
    // degenerate moduli
    setup(64'd0, 64'd5, 5'd2);
    send_req(CMD_FWD, 17'd1);
    send_req(CMD_FWD, 17'd9);
    send_req(CMD_NINV, 17'd0);
    setup(64'd1, 64'd5, 5'd2);
    send_req(CMD_INV, 17'd2);
    send_req(CMD_NINV, 17'd0);
    // q of two, root a multiple of q, zero length exponent
    setup(64'd2, 64'd0, 5'd0);
    send_req(CMD_FWD, 17'd0);
    send_req(CMD_INV, 17'd0);
    send_req(CMD_NINV, 17'd0);
    send_req(CMD_FWD, 17'd1);
    // lengths beyond the index range
    setup(64'd7681, 64'hffff_ffff_ffff_ffff, 5'd31);
    send_req(CMD_FWD, 17'h1ffff);
    send_req(CMD_NINV, 17'd0);
    setup(64'd257, 64'd3, 5'd18);
    send_req(CMD_INV, 17'h15555);
    // widest modulus, a few costly requests only
    setup(64'hffff_ffff_ffff_ffc5, 64'hffff_ffff_ffff_ffff, 5'd17);
    send_req(CMD_FWD, 17'h1ffff);
    send_req(CMD_INV, 17'h0aaaa);
    send_req(CMD_NINV, 17'd0);
  endtask

  task automatic random_phase(logic [63:0] q, logic [4:0] lg, int unsigned cnt, bit hold_off);
    logic [16:0] ix;
    logic [63:0] r;
    r = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 300));
    setup(q, r, lg);
    repeat (cnt) begin
      if ($urandom_range(0, 7) == 0) ix = 17'($urandom);
      else ix = 17'($urandom) & 17'((64'd1 << lg) - 1);
      if (hold_off) drain();
      send_req(cmd_e'(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2)), ix);
    end
  endtask

  task automatic test_random();
    logic [63:0] primes [8];
    primes = '{64'd17, 64'd97, 64'd257, 64'd7681, 64'd12289, 64'd3, 64'd2, 64'd65537};
    for (int p = 0; p < 8; p++) random_phase(primes[p], 5'($urandom_range(1, 8)), 140, 1'b0);
    random_phase(64'd257, 5'd17, 40, 1'b0);
    random_phase(64'd97, 5'd4, 20, 1'b1);
    random_phase(64'hffff_ffff_ffff_ffc5, 5'd1, 4, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    $display("sent %0d requests over %0d register writes, checked %0d results",
             n_sent, n_cfg, n_checked);
    $display("covered all commands, degenerate moduli, out-of-range and wide-length cases");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ntt_twiddle_generator_test: clean");
    end else begin
      $display("ntt_twiddle_generator_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ntt_tw_pkg.sv
hw/rtl/ntt_tw_datapath.sv
hw/rtl/ntt_tw_ctrl.sv
hw/rtl/ntt_twiddle_generator.sv
sim/ntt_twiddle_generator_test.sv
